FILE: hw/rtl/sass_pkg.sv
// Package: types, codes, reset values and helpers for the SPI ADC sample sequencer.
package sass_pkg;

  localparam int unsigned NUM_CHAN = 4;
  localparam logic [3:0] NUM_PORTS = 4'd4;

  typedef enum logic [3:0] {
    M_INIT      = 4'd0,
    M_INIT_BUSY = 4'd1,
    M_BACKOFF   = 4'd2,
    M_IDLE      = 4'd3,
    M_TX        = 4'd4,
    M_RX        = 4'd6,
    M_WAIT      = 4'd8,
    M_ERROR     = 4'd9
  } mode_t;

  typedef enum logic [2:0] {
    FN_SINGLE   = 3'd0,
    FN_START    = 3'd1,
    FN_STOP     = 3'd2,
    FN_TICK     = 3'd3,
    FN_SENT     = 3'd4,
    FN_NOT_BUSY = 3'd5,
    FN_READ     = 3'd6,
    FN_INIT     = 3'd7
  } func_t;

  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_SEND   = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;
  localparam logic [1:0] ACT_SAMPLE = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BUSY    = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_NOPERM  = 3'd3;
  localparam logic [2:0] ST_SEQERR  = 3'd4;

  localparam logic [2:0] REG_CMD_0 = 3'd0;
  localparam logic [2:0] REG_CMD_1 = 3'd1;
  localparam logic [2:0] REG_CMD_2 = 3'd2;
  localparam logic [2:0] REG_CMD_3 = 3'd3;
  localparam logic [2:0] REG_TAG_0 = 3'd4;
  localparam logic [2:0] REG_TAG_1 = 3'd5;
  localparam logic [2:0] REG_TAG_2 = 3'd6;
  localparam logic [2:0] REG_TAG_3 = 3'd7;

  localparam logic [7:0] CMD_RST_0 = 8'd150;
  localparam logic [7:0] CMD_RST_1 = 8'd214;
  localparam logic [7:0] CMD_RST_2 = 8'd166;
  localparam logic [7:0] CMD_RST_3 = 8'd230;

  typedef struct packed {
    mode_t       mode;
    logic        periodic_on;
    logic        single_on;
    logic [1:0]  owner_port;
    logic        owner_set;
    logic        caller_valid;
    logic        cmd_sent;
    logic        adc_idle;
    logic [15:0] samples_started;
    logic [15:0] samples_wanted;
    logic [7:0]  cmd_latch;
  } seq_state_t;

  typedef struct packed {
    seq_state_t  s;
    logic [1:0]  act;
    logic [2:0]  st;
  } conv_t;

  function automatic seq_state_t seq_reset(input seq_state_t s_in);
    seq_state_t r;
    r = s_in;
    r.caller_valid    = 1'b0;
    r.owner_set       = 1'b0;
    r.owner_port      = 2'd0;
    r.periodic_on     = 1'b0;
    r.single_on       = 1'b0;
    r.mode            = M_IDLE;
    r.samples_started = 16'd0;
    return r;
  endfunction

  function automatic conv_t start_conv(input seq_state_t s_in, input logic [1:0] p,
                                       input logic [7:0] cmd);
    conv_t r;
    logic  go;
    r.s   = s_in;
    r.act = ACT_NONE;
    r.st  = ST_OK;
    go    = 1'b0;
    if (s_in.mode == M_INIT_BUSY || s_in.mode == M_TX) begin
      r.st = ST_BUSY;
    end else if (s_in.mode == M_BACKOFF || s_in.mode == M_INIT || s_in.mode == M_IDLE) begin
      if (s_in.mode != M_IDLE) begin
        r.s.mode = M_INIT_BUSY;
      end
      if (!s_in.periodic_on && s_in.owner_set) begin
        r.st = ST_BUSY;
      end else if (s_in.periodic_on && (!s_in.owner_set || s_in.owner_port != p)) begin
        r.st = ST_BUSY;
      end else begin
        if (!s_in.periodic_on) begin
          r.s.single_on = 1'b1;
        end
        if ({2'b00, p} >= NUM_PORTS) begin
          r.st = ST_INVALID;
        end else begin
          r.s.owner_port   = p;
          r.s.owner_set    = 1'b1;
          r.s.caller_valid = 1'b1;
          r.s.cmd_latch    = cmd;
          go               = 1'b1;
        end
      end
    end else if (s_in.mode != M_WAIT) begin
      r.s  = seq_reset(s_in);
      r.st = ST_INVALID;
    end else begin
      go = 1'b1;
    end
    if (go) begin
      r.s.cmd_sent = 1'b0;
      r.s.adc_idle = 1'b0;
      if (r.s.mode != M_INIT_BUSY) begin
        r.s.mode = M_TX;
      end
      r.act = ACT_SEND;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/spi_adc_sample_sequencer_top.sv
// Top level: event-driven sample sequencer for a four-channel SPI converter.
// Each input beat is one event and yields exactly one result beat. When an
// event is taken, the sequencer state updates and the result lands in the
// output register on the accepting edge, so a new event is accepted every cycle
// while the output register is empty or being drained; throughput is one event
// per clock. The configuration port is always ready; the user must write it
// only while the block is idle, which the block itself does not enforce.
module spi_adc_sample_sequencer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // port[1:0], forced[2], sample_count[18:3], rx_byte_hi[26:19],
  // rx_byte_mid[34:27], rx_byte_lo[42:35], rx_len[44:43], zero pad [47:45]
  input  logic [47:0] s_tdata,
  // func[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // command_byte[7:0], sample_value[23:8], sample_tag[31:24], status[34:32],
  // zero pad [39:35]
  output logic [39:0] m_tdata,
  // action[1:0]
  output logic [1:0]  m_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0] chan_cmd [sass_pkg::NUM_CHAN];
  logic [7:0] tag      [sass_pkg::NUM_CHAN];

  sass_pkg::seq_state_t seq;
  sass_pkg::seq_state_t seq_next;
  sass_pkg::conv_t      conv;

  sass_pkg::func_t ev_func;
  logic [1:0]  ev_port;
  logic        ev_force;
  logic [15:0] ev_count;
  logic [7:0]  ev_hi;
  logic [7:0]  ev_mid;
  logic [7:0]  ev_lo;
  logic [1:0]  ev_len;

  logic [1:0]  act;
  logic [2:0]  st;
  logic [15:0] value;
  logic [7:0]  tg;
  logic [7:0]  cmd_out;
  logic        accept;

  assign ev_func  = sass_pkg::func_t'(s_tuser);
  assign ev_port  = s_tdata[1:0];
  assign ev_force = s_tdata[2];
  assign ev_count = s_tdata[18:3];
  assign ev_hi    = s_tdata[26:19];
  assign ev_mid   = s_tdata[34:27];
  assign ev_lo    = s_tdata[42:35];
  assign ev_len   = s_tdata[44:43];

  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    seq_next = seq;
    conv     = '0;
    act      = sass_pkg::ACT_NONE;
    st       = sass_pkg::ST_OK;
    value    = 16'd0;
    tg       = 8'd0;
    unique case (ev_func)
      sass_pkg::FN_SINGLE: begin
        conv     = sass_pkg::start_conv(seq, ev_port, chan_cmd[ev_port]);
        seq_next = conv.s;
        act      = conv.act;
        st       = conv.st;
      end
      sass_pkg::FN_START: begin
        if (seq.owner_set) begin
          st = sass_pkg::ST_BUSY;
        end else begin
          seq_next.samples_wanted  = ev_count;
          seq_next.samples_started = 16'd0;
          seq_next.owner_port      = ev_port;
          seq_next.owner_set       = 1'b1;
          seq_next.periodic_on     = 1'b1;
          seq_next.single_on       = 1'b0;
        end
      end
      sass_pkg::FN_STOP: begin
        if (!ev_force && (!seq.owner_set || seq.owner_port != ev_port)) begin
          st = sass_pkg::ST_NOPERM;
        end else begin
          seq_next = sass_pkg::seq_reset(seq);
        end
      end
      sass_pkg::FN_TICK: begin
        if (seq.periodic_on) begin
          conv = sass_pkg::start_conv(seq, seq.owner_port, chan_cmd[seq.owner_port]);
          act  = conv.act;
          st   = conv.st;
          if (conv.st != sass_pkg::ST_OK) begin
            seq_next = sass_pkg::seq_reset(conv.s);
          end else begin
            seq_next = conv.s;
          end
        end
      end
      sass_pkg::FN_SENT: begin
        seq_next.cmd_sent = 1'b1;
        if (seq.adc_idle) begin
          seq_next.samples_started = seq.samples_started + 16'd1;
          if (seq.mode != sass_pkg::M_INIT_BUSY) begin
            seq_next.mode = sass_pkg::M_RX;
          end
          act = sass_pkg::ACT_READ;
        end
      end
      sass_pkg::FN_NOT_BUSY: begin
        seq_next.adc_idle = 1'b1;
        if (seq.mode != sass_pkg::M_TX && seq.mode != sass_pkg::M_INIT_BUSY) begin
          seq_next = sass_pkg::seq_reset(seq_next);
          st       = sass_pkg::ST_SEQERR;
        end else if (seq.cmd_sent) begin
          seq_next.samples_started = seq.samples_started + 16'd1;
          if (seq.mode != sass_pkg::M_INIT_BUSY) begin
            seq_next.mode = sass_pkg::M_RX;
          end
          act = sass_pkg::ACT_READ;
        end
      end
      sass_pkg::FN_READ: begin
        if (seq.mode != sass_pkg::M_INIT_BUSY && seq.caller_valid && ev_len == 2'd3) begin
          value = {ev_hi[6:0], ev_mid, ev_lo[7]};
          tg    = tag[seq.owner_port];
          act   = sass_pkg::ACT_SAMPLE;
        end
        if (seq.periodic_on && seq.samples_started < seq.samples_wanted) begin
          seq_next.mode = sass_pkg::M_WAIT;
        end else begin
          seq_next = sass_pkg::seq_reset(seq);
        end
      end
      sass_pkg::FN_INIT: begin
        seq_next.owner_set   = 1'b0;
        seq_next.owner_port  = 2'd0;
        seq_next.periodic_on = 1'b0;
        seq_next.single_on   = 1'b0;
        conv     = sass_pkg::start_conv(seq_next, 2'd0, chan_cmd[0]);
        seq_next = conv.s;
        act      = conv.act;
        st       = conv.st;
        if (conv.st != sass_pkg::ST_OK) begin
          seq_next.owner_set   = 1'b0;
          seq_next.owner_port  = 2'd0;
          seq_next.periodic_on = 1'b0;
          seq_next.single_on   = 1'b0;
        end
        seq_next.caller_valid = 1'b0;
        seq_next.mode         = sass_pkg::M_INIT_BUSY;
      end
      default: begin
        seq_next = seq;
      end
    endcase
    cmd_out = (act == sass_pkg::ACT_SEND) ? seq_next.cmd_latch : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq.mode            <= sass_pkg::M_INIT;
      seq.periodic_on     <= 1'b0;
      seq.single_on       <= 1'b0;
      seq.owner_port      <= 2'd0;
      seq.owner_set       <= 1'b0;
      seq.caller_valid    <= 1'b0;
      seq.cmd_sent        <= 1'b0;
      seq.adc_idle        <= 1'b0;
      seq.samples_started <= 16'd0;
      seq.samples_wanted  <= 16'd0;
      seq.cmd_latch       <= 8'd0;
    end else if (accept) begin
      seq <= seq_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_cmd[0] <= sass_pkg::CMD_RST_0;
      chan_cmd[1] <= sass_pkg::CMD_RST_1;
      chan_cmd[2] <= sass_pkg::CMD_RST_2;
      chan_cmd[3] <= sass_pkg::CMD_RST_3;
      tag[0]      <= 8'd0;
      tag[1]      <= 8'd1;
      tag[2]      <= 8'd2;
      tag[3]      <= 8'd3;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sass_pkg::REG_CMD_0: chan_cmd[0] <= cfg_data;
        sass_pkg::REG_CMD_1: chan_cmd[1] <= cfg_data;
        sass_pkg::REG_CMD_2: chan_cmd[2] <= cfg_data;
        sass_pkg::REG_CMD_3: chan_cmd[3] <= cfg_data;
        sass_pkg::REG_TAG_0: tag[0]      <= cfg_data;
        sass_pkg::REG_TAG_1: tag[1]      <= cfg_data;
        sass_pkg::REG_TAG_2: tag[2]      <= cfg_data;
        sass_pkg::REG_TAG_3: tag[3]      <= cfg_data;
        default: tag[3] <= tag[3];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {5'd0, st, tg, value, cmd_out};
      m_tuser <= act;
    end
  end

endmodule

FILE: tb/tb_spi_adc_sample_sequencer_top.sv
// Testbench for the SPI ADC sample sequencer: directed table, then random event streams.
module tb_spi_adc_sample_sequencer_top;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 210;
  localparam int DIRECTED_ROWS = 27;

  typedef struct packed {
    sass_pkg::func_t func;
    logic [1:0]  port;
    logic        forced;
    logic [15:0] count;
    logic [7:0]  hi;
    logic [7:0]  mid;
    logic [7:0]  lo;
    logic [1:0]  len;
  } adc_event_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  cmd;
    logic [15:0] value;
    logic [7:0]  tag;
    logic [2:0]  status;
  } outcome_t;

  typedef struct packed {
    adc_event_t ev;
    logic       typed;
    outcome_t   want;
  } directed_row_t;

  typedef struct {
    sass_pkg::mode_t mode;
    logic        periodic;
    logic        single;
    logic [1:0]  owner;
    logic        owned;
    logic        caller;
    logic        cmd_sent;
    logic        adc_ready;
    logic [15:0] started;
    logic [15:0] wanted;
    logic [7:0]  latch;
  } sequencer_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;

  sequencer_t    tracked;
  logic [7:0]    cmd_bytes [4];
  logic [7:0]    tag_bytes [4];
  logic [7:0]    reg_plan [8];
  outcome_t      awaited_results [$];
  directed_row_t directed [DIRECTED_ROWS];
  int            mismatches = 0;
  int            beats_checked = 0;
  int            stream_count = 0;
  int            quiet_cycles = 0;
  bit            no_stalls = 1'b0;

  spi_adc_sample_sequencer_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] wanted);
    if (mismatches < 100) begin
      $display("mismatch in %s at beat %0d: got %h, expected %h", field, beats_checked, got,
               wanted);
    end
    mismatches++;
  endtask

  task automatic reset_tracking();
    tracked = '{mode: sass_pkg::M_INIT, default: '0};
    cmd_bytes[0] = sass_pkg::CMD_RST_0;
    cmd_bytes[1] = sass_pkg::CMD_RST_1;
    cmd_bytes[2] = sass_pkg::CMD_RST_2;
    cmd_bytes[3] = sass_pkg::CMD_RST_3;
    for (int i = 0; i < 4; i++) begin
      tag_bytes[i] = 8'(i);
    end
  endtask

  function automatic void restart_sequence();
    tracked.caller   = 1'b0;
    tracked.owned    = 1'b0;
    tracked.owner    = 2'd0;
    tracked.periodic = 1'b0;
    tracked.single   = 1'b0;
    tracked.mode     = sass_pkg::M_IDLE;
    tracked.started  = 16'd0;
  endfunction

  function automatic void launch_conversion(input logic [1:0] p, inout logic [1:0] act,
                                            output logic [2:0] st);
    logic go;
    st = sass_pkg::ST_OK;
    go = 1'b0;
    case (tracked.mode)
      sass_pkg::M_INIT_BUSY, sass_pkg::M_TX: begin
        st = sass_pkg::ST_BUSY;
      end
      sass_pkg::M_BACKOFF, sass_pkg::M_INIT, sass_pkg::M_IDLE: begin
        if (tracked.mode != sass_pkg::M_IDLE) tracked.mode = sass_pkg::M_INIT_BUSY;
        if (!tracked.periodic && tracked.owned) begin
          st = sass_pkg::ST_BUSY;
        end else if (tracked.periodic && (!tracked.owned || tracked.owner != p)) begin
          st = sass_pkg::ST_BUSY;
        end else begin
          if (!tracked.periodic) tracked.single = 1'b1;
          if ({2'b00, p} >= sass_pkg::NUM_PORTS) begin
            st = sass_pkg::ST_INVALID;
          end else begin
            tracked.owner  = p;
            tracked.owned  = 1'b1;
            tracked.caller = 1'b1;
            tracked.latch  = cmd_bytes[p];
            go = 1'b1;
          end
        end
      end
      sass_pkg::M_WAIT: begin
        go = 1'b1;
      end
      default: begin
        restart_sequence();
        st = sass_pkg::ST_INVALID;
      end
    endcase
    if (go) begin
      tracked.cmd_sent  = 1'b0;
      tracked.adc_ready = 1'b0;
      if (tracked.mode != sass_pkg::M_INIT_BUSY) tracked.mode = sass_pkg::M_TX;
      act = sass_pkg::ACT_SEND;
    end
  endfunction

  function automatic void begin_frame_read(inout logic [1:0] act);
    tracked.started = tracked.started + 16'd1;
    if (tracked.mode != sass_pkg::M_INIT_BUSY) tracked.mode = sass_pkg::M_RX;
    act = sass_pkg::ACT_READ;
  endfunction

  function automatic outcome_t next_result(input adc_event_t ev);
    outcome_t r;
    logic [1:0] act;
    logic [2:0] st;
    act = sass_pkg::ACT_NONE;
    st = sass_pkg::ST_OK;
    r = '0;
    case (ev.func)
      sass_pkg::FN_SINGLE: launch_conversion(ev.port, act, st);
      sass_pkg::FN_START: begin
        if (tracked.owned) begin
          st = sass_pkg::ST_BUSY;
        end else begin
          tracked.wanted   = ev.count;
          tracked.started  = 16'd0;
          tracked.owner    = ev.port;
          tracked.owned    = 1'b1;
          tracked.periodic = 1'b1;
          tracked.single   = 1'b0;
        end
      end
      sass_pkg::FN_STOP: begin
        if (!ev.forced && (!tracked.owned || tracked.owner != ev.port)) begin
          st = sass_pkg::ST_NOPERM;
        end else begin
          restart_sequence();
        end
      end
      sass_pkg::FN_TICK: begin
        if (tracked.periodic) begin
          launch_conversion(tracked.owner, act, st);
          if (st != sass_pkg::ST_OK) restart_sequence();
        end
      end
      sass_pkg::FN_SENT: begin
        tracked.cmd_sent = 1'b1;
        if (tracked.adc_ready) begin_frame_read(act);
      end
      sass_pkg::FN_NOT_BUSY: begin
        tracked.adc_ready = 1'b1;
        if (tracked.mode != sass_pkg::M_TX && tracked.mode != sass_pkg::M_INIT_BUSY) begin
          restart_sequence();
          st = sass_pkg::ST_SEQERR;
        end else if (tracked.cmd_sent) begin
          begin_frame_read(act);
        end
      end
      sass_pkg::FN_READ: begin
        if (tracked.mode != sass_pkg::M_INIT_BUSY && tracked.caller && ev.len == 2'd3) begin
          r.value = {ev.hi[6:0], ev.mid, ev.lo[7]};
          r.tag   = tag_bytes[tracked.owner];
          act     = sass_pkg::ACT_SAMPLE;
        end
        if (tracked.periodic && tracked.started < tracked.wanted) begin
          tracked.mode = sass_pkg::M_WAIT;
        end else begin
          restart_sequence();
        end
      end
      default: begin
        tracked.owned    = 1'b0;
        tracked.owner    = 2'd0;
        tracked.periodic = 1'b0;
        tracked.single   = 1'b0;
        launch_conversion(2'd0, act, st);
        if (st != sass_pkg::ST_OK) begin
          tracked.owned    = 1'b0;
          tracked.owner    = 2'd0;
          tracked.periodic = 1'b0;
          tracked.single   = 1'b0;
        end
        tracked.caller = 1'b0;
        tracked.mode   = sass_pkg::M_INIT_BUSY;
      end
    endcase
    r.action = act;
    r.cmd    = (act == sass_pkg::ACT_SEND) ? tracked.latch : 8'd0;
    r.status = st;
    return r;
  endfunction

  function automatic adc_event_t evt(input sass_pkg::func_t f, input logic [1:0] p,
                                     input logic fs,
                                     input logic [15:0] c, input logic [7:0] h,
                                     input logic [7:0] m, input logic [7:0] l,
                                     input logic [1:0] n);
    return '{f, p, fs, c, h, m, l, n};
  endfunction

  function automatic outcome_t outc(input logic [1:0] a, input logic [7:0] c,
                                    input logic [15:0] v, input logic [7:0] t,
                                    input logic [2:0] s);
    return '{a, c, v, t, s};
  endfunction

  function automatic adc_event_t fresh_event(input sass_pkg::func_t f);
    adc_event_t ev;
    ev.func   = f;
    ev.port   = 2'($urandom_range(0, 3));
    ev.forced = 1'($urandom_range(0, 1));
    ev.count  = 16'($urandom_range(0, 65535));
    ev.hi     = 8'($urandom_range(0, 255));
    ev.mid    = 8'($urandom_range(0, 255));
    ev.lo     = 8'($urandom_range(0, 255));
    ev.len    = 2'($urandom_range(0, 3));
    return ev;
  endfunction

  task automatic deliver(input adc_event_t ev, output outcome_t predicted);
    int gap;
    gap = no_stalls ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      @(negedge clk) s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= ev.func;
    s_tdata  <= {3'b000, ev.len, ev.lo, ev.mid, ev.hi, ev.count, ev.forced, ev.port};
    do @(posedge clk); while (!s_tready);
    predicted = next_result(ev);
  endtask

  task automatic play(input adc_event_t ev);
    outcome_t predicted;
    deliver(ev, predicted);
    awaited_results.push_back(predicted);
    stream_count++;
  endtask

  task automatic step(input adc_event_t ev);
    if ($urandom_range(0, 19) == 0) play(fresh_event(sass_pkg::func_t'($urandom_range(0, 7))));
    play(ev);
  endtask

  task automatic finish_conversion();
    adc_event_t ev;
    if ($urandom_range(0, 1) == 1) begin
      step(fresh_event(sass_pkg::FN_SENT));
      step(fresh_event(sass_pkg::FN_NOT_BUSY));
    end else begin
      step(fresh_event(sass_pkg::FN_NOT_BUSY));
      step(fresh_event(sass_pkg::FN_SENT));
    end
    ev = fresh_event(sass_pkg::FN_READ);
    if ($urandom_range(0, 99) < 85) ev.len = 2'd3;
    step(ev);
  endtask

  task automatic periodic_run();
    adc_event_t ev;
    logic [1:0] p;
    int rounds;
    ev = fresh_event(sass_pkg::FN_START);
    p = ev.port;
    if ($urandom_range(0, 9) < 7) ev.count = 16'($urandom_range(0, 4));
    rounds = (ev.count > 16'd4) ? 4 : int'(ev.count);
    step(ev);
    for (int i = 0; i < rounds; i++) begin
      step(fresh_event(sass_pkg::FN_TICK));
      finish_conversion();
    end
    if (ev.count > 16'(rounds) || $urandom_range(0, 3) == 0) begin
      ev = fresh_event(sass_pkg::FN_STOP);
      if ($urandom_range(0, 3) != 0) ev.port = p;
      step(ev);
    end
  endtask

  task automatic drain();
    @(negedge clk) s_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic program_registers();
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= sass_pkg::REG_CMD_0 + 3'(i);
      cfg_data  <= reg_plan[i];
      do @(posedge clk); while (!cfg_ready);
      if (sass_pkg::REG_CMD_0 + 3'(i) < sass_pkg::REG_TAG_0) cmd_bytes[i] = reg_plan[i];
      else tag_bytes[i - 4] = reg_plan[i];
    end
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic check_beat();
    outcome_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch("beat with nothing expected", 16'(m_tuser), 16'd0);
      return;
    end
    want = awaited_results.pop_front();
    if (m_tuser !== want.action) report_mismatch("action", 16'(m_tuser), 16'(want.action));
    if (m_tdata[7:0] !== want.cmd) report_mismatch("command_byte", 16'(m_tdata[7:0]),
                                                   16'(want.cmd));
    if (m_tdata[23:8] !== want.value) report_mismatch("sample_value", m_tdata[23:8], want.value);
    if (m_tdata[31:24] !== want.tag) report_mismatch("sample_tag", 16'(m_tdata[31:24]),
                                                     16'(want.tag));
    if (m_tdata[34:32] !== want.status) report_mismatch("status", 16'(m_tdata[34:32]),
                                                        16'(want.status));
    beats_checked++;
  endtask

  initial begin
    int wait_cycles;
    m_tready = 1'b0;
    forever begin
      wait_cycles = no_stalls ? 0 : $urandom_range(0, 10);
      if (wait_cycles != 0) begin
        @(negedge clk) m_tready <= 1'b0;
        repeat (wait_cycles - 1) @(negedge clk);
      end
      @(negedge clk) m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid === 1'b1 && !rst));
      check_beat();
    end
  end

  initial begin
    outcome_t guess;
    int pick;
    bit paused;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = sass_pkg::FN_SINGLE;
    cfg_valid = 1'b0;
    cfg_index = sass_pkg::REG_CMD_0;
    cfg_data  = 8'd0;
    rst       = 1'b1;
    paused    = 1'b0;
    reset_tracking();

    directed[0]  = '{evt(sass_pkg::FN_NOT_BUSY, 0, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 0), 1'b1,
                     outc(sass_pkg::ACT_NONE, 0, 0, 0, sass_pkg::ST_SEQERR)};
    directed[1]  = '{evt(sass_pkg::FN_STOP, 1, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 0), 1'b1,
                     outc(sass_pkg::ACT_NONE, 0, 0, 0, sass_pkg::ST_NOPERM)};
    directed[2]  = '{evt(sass_pkg::FN_TICK, 2, 1, 16'hffff, 8'hff, 8'hff, 8'hff, 3), 1'b1,
                     outc(sass_pkg::ACT_NONE, 0, 0, 0, sass_pkg::ST_OK)};
    directed[3]  = '{evt(sass_pkg::FN_SINGLE, 3, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 0), 1'b1,
                     outc(sass_pkg::ACT_SEND, sass_pkg::CMD_RST_3, 0, 0, sass_pkg::ST_OK)};
    directed[4]  = '{evt(sass_pkg::FN_SINGLE, 0, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 0), 1'b1,
                     outc(sass_pkg::ACT_NONE, 0, 0, 0, sass_pkg::ST_BUSY)};
    directed[5]  = '{evt(sass_pkg::FN_SENT, 0, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 0), 1'b0,
                     '0};
    directed[6]  = '{evt(sass_pkg::FN_NOT_BUSY, 0, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 0), 1'b0,
                     '0};
    directed[7]  = '{evt(sass_pkg::FN_READ, 0, 0, 16'h0000, 8'hff, 8'hff, 8'hff, 3), 1'b1,
                     outc(sass_pkg::ACT_SAMPLE, 0, 16'hffff, 8'd3, sass_pkg::ST_OK)};
    directed[8]  = '{evt(sass_pkg::FN_SINGLE, 0, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 0), 1'b0,
                     '0};
    directed[9]  = '{evt(sass_pkg::FN_NOT_BUSY, 0, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 0), 1'b0,
                     '0};
    directed[10] = '{evt(sass_pkg::FN_SINGLE, 1, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 0), 1'b1,
                     outc(sass_pkg::ACT_NONE, 0, 0, 0, sass_pkg::ST_BUSY)};
    directed[11] = '{evt(sass_pkg::FN_SENT, 0, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 0), 1'b0,
                     '0};
    directed[12] = '{evt(sass_pkg::FN_SINGLE, 2, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 0), 1'b1,
                     outc(sass_pkg::ACT_NONE, 0, 0, 0, sass_pkg::ST_INVALID)};
    directed[13] = '{evt(sass_pkg::FN_READ, 0, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 3), 1'b0,
                     '0};
    directed[14] = '{evt(sass_pkg::FN_START, 2, 1, 16'hffff, 8'h00, 8'h00, 8'h00, 0), 1'b0,
                     '0};
    directed[15] = '{evt(sass_pkg::FN_START, 1, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 0), 1'b1,
                     outc(sass_pkg::ACT_NONE, 0, 0, 0, sass_pkg::ST_BUSY)};
    directed[16] = '{evt(sass_pkg::FN_STOP, 1, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 0), 1'b1,
                     outc(sass_pkg::ACT_NONE, 0, 0, 0, sass_pkg::ST_NOPERM)};
    directed[17] = '{evt(sass_pkg::FN_TICK, 0, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 0), 1'b0,
                     '0};
    directed[18] = '{evt(sass_pkg::FN_TICK, 0, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 0), 1'b1,
                     outc(sass_pkg::ACT_NONE, 0, 0, 0, sass_pkg::ST_BUSY)};
    directed[19] = '{evt(sass_pkg::FN_START, 0, 0, 16'h0001, 8'h00, 8'h00, 8'h00, 0), 1'b0,
                     '0};
    directed[20] = '{evt(sass_pkg::FN_SINGLE, 0, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 0), 1'b0,
                     '0};
    directed[21] = '{evt(sass_pkg::FN_SENT, 0, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 0), 1'b0,
                     '0};
    directed[22] = '{evt(sass_pkg::FN_NOT_BUSY, 0, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 0), 1'b0,
                     '0};
    directed[23] = '{evt(sass_pkg::FN_READ, 0, 0, 16'h0000, 8'h80, 8'h01, 8'h80, 2), 1'b0,
                     '0};
    directed[24] = '{evt(sass_pkg::FN_STOP, 3, 1, 16'h0000, 8'h00, 8'h00, 8'h00, 0), 1'b0,
                     '0};
    directed[25] = '{evt(sass_pkg::FN_INIT, 0, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 0), 1'b1,
                     outc(sass_pkg::ACT_SEND, sass_pkg::CMD_RST_0, 0, 0, sass_pkg::ST_OK)};
    directed[26] = '{evt(sass_pkg::FN_READ, 0, 0, 16'h0000, 8'hff, 8'hff, 8'hff, 3), 1'b0,
                     '0};

    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      deliver(directed[i].ev, guess);
      awaited_results.push_back(directed[i].typed ? directed[i].want : guess);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      no_stalls = (phase == 3);
      for (int i = 0; i < 8; i++) begin
        case (phase)
          0: reg_plan[i] = 8'h00;
          1: reg_plan[i] = 8'hff;
          default: reg_plan[i] = 8'($urandom_range(0, 255));
        endcase
      end
      program_registers();
      stream_count = 0;
      while (stream_count < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          step(fresh_event(sass_pkg::FN_SINGLE));
          finish_conversion();
        end else if (pick < 65) begin
          periodic_run();
        end else if (pick < 75) begin
          step(fresh_event(sass_pkg::FN_INIT));
          finish_conversion();
        end else begin
          repeat ($urandom_range(1, 3)) begin
            play(fresh_event(sass_pkg::func_t'($urandom_range(0, 7))));
          end
        end
        if (phase == 2 && !paused && stream_count >= PHASE_ITEMS / 2) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/sass_pkg.sv
hw/rtl/spi_adc_sample_sequencer_top.sv
tb/tb_spi_adc_sample_sequencer_top.sv
